>>> rtl/sac_pkg.sv
// Shared types and constants for the source address info cache.
`timescale 1ns / 1ps
`default_nettype none
package sac_pkg;

    localparam int ENTRY_COUNT_DEF = 500;
    localparam int SLOT_COUNT_DEF  = 1024;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] MIX_MUL_A  = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B  = 32'h846ca68b;
    localparam logic [31:0] FAM_V4_TAG = 32'd2;
    localparam logic [31:0] FAM_V6_TAG = 32'd10;

    typedef struct packed {
        logic        operation;
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  hop_limit;
        logic [63:0] hw_address;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  hop_limit_out;
        logic [63:0] hw_address_out;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/source_address_info_cache.sv
// Top level of the source address info cache.
`timescale 1ns / 1ps
`default_nettype none
// Keyed cache of hop limit and hardware address per IPv4/IPv6 source address.
// A command is taken when start is high and busy low; its result appears on
// result for one cycle with done high and cannot be held off. After reset the
// slot table is cleared with busy high. The hashing front end runs 16 FNV
// byte steps for an IPv6 key, then 3 mixer steps, 3 remainder steps and 1
// handoff; an IPv4 key skips the FNV steps. The table engine reads, checks
// and compares each probed slot in turn on the slot and entry memories (one
// read and one write port each), and runs the cluster rehash when a valid
// entry is evicted. The front end can take a new command while the table
// engine works on earlier ones, the halves overlapping through a two-beat queue.
module source_address_info_cache #(
    parameter int ENTRY_COUNT = sac_pkg::ENTRY_COUNT_DEF,
    parameter int SLOT_COUNT  = sac_pkg::SLOT_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sac_pkg::cmd_t cmd,
    output logic               busy,
    output logic               done,
    output sac_pkg::result_t   result
);
    import sac_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int JW = $bits(cmd_t) + SW;

    logic          ready;
    logic          q_full;
    logic          push;
    cmd_t          job_cmd;
    logic [SW-1:0] job_home;
    logic          pop;
    logic          q_valid;
    logic [JW-1:0] q_data;

    sac_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .ready    (ready),
        .busy     (busy),
        .q_full   (q_full),
        .push     (push),
        .job_cmd  (job_cmd),
        .job_home (job_home)
    );

    sac_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({job_home, job_cmd}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    sac_back #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (ready),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_MISS ||
                  result.status == ST_FULL))
        else $error("unknown status code");

    a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |->
            result.hop_limit_out == 8'd0 && result.hw_address_out == 64'd0)
        else $error("data reported on a failed beat");
`endif
endmodule
`default_nettype wire

>>> rtl/sac_fifo.sv
// Two-entry queue between the hashing front end and the table engine.
`timescale 1ns / 1ps
`default_nettype none
module sac_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/sac_front.sv
// Front end: takes a command, hashes the key and reduces it to a home slot.
`timescale 1ns / 1ps
`default_nettype none
module sac_front #(
    parameter int SLOT_COUNT = sac_pkg::SLOT_COUNT_DEF,
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sac_pkg::cmd_t cmd,
    input  wire logic          ready,
    output logic               busy,
    input  wire logic          q_full,
    output logic               push,
    output sac_pkg::cmd_t      job_cmd,
    output logic [SW-1:0]      job_home
);
    import sac_pkg::*;

    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / SLOT_COUNT);
    localparam logic [31:0] SLOTS32 = 32'(SLOT_COUNT);

    typedef enum logic [3:0] {
        F_IDLE, F_FNV, F_MIX_A, F_MIX_B, F_MIX_C, F_MOD_A, F_MOD_B, F_MOD_C, F_PUSH
    } state_t;

    state_t         state_reg,  state_next;
    logic [31:0]    x_reg,      x_next;
    logic [127:0]   key_reg,    key_next;
    logic [3:0]     cnt_reg,    cnt_next;
    cmd_t           cmd_reg,    cmd_next;
    logic [SW-1:0]  rem_reg,    rem_next;
    logic [31:0]    q_reg,      q_next;

    logic [31:0]    fnv_step;
    logic [31:0]    mix_a;
    logic [31:0]    mix_b;
    logic [63:0]    recip_prod;
    logic [31:0]    red_sub;

    assign busy     = (state_reg != F_IDLE) || !ready;
    assign push     = (state_reg == F_PUSH) && !q_full;
    assign job_cmd  = cmd_reg;
    assign job_home = rem_reg;

    assign fnv_step = 32'((x_reg ^ {24'd0, key_reg[127:120]}) * FNV_PRIME);
    assign mix_a    = 32'((x_reg ^ (x_reg >> 16)) * MIX_MUL_A);
    assign mix_b    = 32'((x_reg ^ (x_reg >> 15)) * MIX_MUL_B);

    // quotient estimate from the reciprocal is at most one short
    assign recip_prod = 64'(x_reg) * 64'(RECIP);
    assign red_sub    = x_reg - SLOTS32;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start && ready)
                begin
                    cmd_next = cmd;
                    cnt_next = 4'd0;
                    if (cmd.is_ipv6)
                    begin
                        key_next   = {cmd.addr_high, cmd.addr_low};
                        x_next     = FNV_BASIS;
                        state_next = F_FNV;
                    end
                    else
                    begin
                        cmd_next.addr_high = '0;
                        cmd_next.addr_low  = {32'd0, cmd.addr_low[31:0]};
                        x_next     = cmd.addr_low[31:0] ^ FAM_V4_TAG;
                        state_next = F_MIX_A;
                    end
                end
            end
            F_FNV:
            begin
                key_next = key_reg << 8;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    x_next     = fnv_step ^ FAM_V6_TAG;
                    state_next = F_MIX_A;
                end
                else
                begin
                    x_next = fnv_step;
                end
            end
            F_MIX_A:
            begin
                x_next     = mix_a;
                state_next = F_MIX_B;
            end
            F_MIX_B:
            begin
                x_next     = mix_b;
                state_next = F_MIX_C;
            end
            F_MIX_C:
            begin
                x_next     = x_reg ^ (x_reg >> 16);
                state_next = F_MOD_A;
            end
            F_MOD_A:
            begin
                q_next     = recip_prod[63:32];
                state_next = F_MOD_B;
            end
            F_MOD_B:
            begin
                x_next     = x_reg - 32'(q_reg * SLOTS32);
                state_next = F_MOD_C;
            end
            F_MOD_C:
            begin
                rem_next   = (x_reg >= SLOTS32) ? SW'(red_sub) : SW'(x_reg);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        key_reg <= key_next;
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end
endmodule
`default_nettype wire

>>> rtl/sac_back.sv
// Table engine: slot probing, eviction with cluster rehash, insert and lookup.
`timescale 1ns / 1ps
`default_nettype none
module sac_back #(
    parameter int ENTRY_COUNT = sac_pkg::ENTRY_COUNT_DEF,
    parameter int SLOT_COUNT  = sac_pkg::SLOT_COUNT_DEF,
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int JW = $bits(sac_pkg::cmd_t) + SW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               ready,
    input  wire logic          q_valid,
    input  wire logic [JW-1:0] q_data,
    output logic               pop,
    output logic               done,
    output sac_pkg::result_t   result
);
    import sac_pkg::*;

    localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CW = $bits(cmd_t);

    typedef struct packed {
        logic          used;
        logic [EW-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic          fam;
        logic [63:0]   hi;
        logic [63:0]   lo;
        logic [SW-1:0] home;
        logic [7:0]    hop;
        logic [63:0]   hw;
    } entry_t;

    typedef enum logic [4:0] {
        B_CLEAR, B_IDLE, B_F_RD, B_F_SLOT, B_F_ENT, B_E_RD, B_E_HOME,
        B_R_RD, B_R_CHK, B_H_RD, B_H_CHK, B_H_ENT, B_I_RD, B_I_CHK,
        B_P_WR, B_P_RD, B_P_CHK
    } state_t;

    slot_t  slot_mem  [SLOT_COUNT];
    entry_t entry_mem [ENTRY_COUNT];
    slot_t  slot_q;
    entry_t entry_q;

    state_t         state_reg, state_next;
    logic [SW-1:0]  s_reg,     s_next;
    logic [SW-1:0]  t_reg,     t_next;
    logic [SW:0]    n_reg,     n_next;
    logic [SW:0]    m_reg,     m_next;
    logic [EW-1:0]  moved_reg, moved_next;
    logic [EW-1:0]  vp_reg,    vp_next;
    logic           wrap_reg,  wrap_next;
    logic [JW-1:0]  job_reg,   job_next;
    logic           done_reg,  done_next;
    result_t        res_reg,   res_next;

    cmd_t           job_cmd;
    logic [SW-1:0]  job_home;
    logic [SW-1:0]  slot_raddr;
    logic [EW-1:0]  entry_raddr;
    logic           slot_we;
    logic [SW-1:0]  slot_waddr;
    slot_t          slot_wdata;
    logic           entry_we;
    logic [EW-1:0]  entry_waddr;
    entry_t         entry_wdata;
    logic           key_match;

    function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
        inc_slot = (s == SW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

    assign job_cmd  = job_reg[CW-1:0];
    assign job_home = job_reg[JW-1:CW];
    assign ready    = (state_reg != B_CLEAR);
    assign done     = done_reg;
    assign result   = res_reg;

    assign slot_raddr  = (state_reg == B_I_RD) ? t_reg : s_reg;
    assign entry_raddr = (state_reg == B_E_RD) ? vp_reg : slot_q.idx;

    assign entry_wdata = '{fam: job_cmd.is_ipv6, hi: job_cmd.addr_high,
                           lo: job_cmd.addr_low, home: job_home,
                           hop: job_cmd.hop_limit, hw: job_cmd.hw_address};

    assign key_match = (entry_q.fam == job_cmd.is_ipv6) &&
                       (entry_q.hi == job_cmd.addr_high) &&
                       (entry_q.lo == job_cmd.addr_low);

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        t_next      = t_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        moved_next  = moved_reg;
        vp_next     = vp_reg;
        wrap_next   = wrap_reg;
        job_next    = job_reg;
        done_next   = 1'b0;
        res_next    = '0;
        pop         = 1'b0;
        slot_we     = 1'b0;
        slot_waddr  = s_reg;
        slot_wdata  = '0;
        entry_we    = 1'b0;
        entry_waddr = vp_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                slot_we = 1'b1;
                s_next  = inc_slot(s_reg);
                if (s_reg == SW'(SLOT_COUNT - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    job_next   = q_data;
                    s_next     = q_data[JW-1:CW];
                    n_next     = '0;
                    state_next = B_F_RD;
                end
            end
            B_F_RD:
            begin
                state_next = B_F_SLOT;
            end
            B_F_SLOT:
            begin
                if (!slot_q.used)
                begin
                    if (job_cmd.operation == OP_GET)
                    begin
                        done_next       = 1'b1;
                        res_next.status = ST_MISS;
                        state_next      = B_IDLE;
                    end
                    else if (wrap_reg)
                    begin
                        state_next = B_E_RD;
                    end
                    else
                    begin
                        state_next = B_P_WR;
                    end
                end
                else
                begin
                    state_next = B_F_ENT;
                end
            end
            B_F_ENT:
            begin
                if (key_match)
                begin
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                    if (job_cmd.operation == OP_GET)
                    begin
                        res_next.hop_limit_out  = entry_q.hop;
                        res_next.hw_address_out = entry_q.hw;
                    end
                    else
                    begin
                        entry_we    = 1'b1;
                        entry_waddr = slot_q.idx;
                    end
                end
                else
                begin
                    s_next = inc_slot(s_reg);
                    n_next = n_reg + 1'b1;
                    if (n_reg + 1'b1 == (SW+1)'(SLOT_COUNT))
                    begin
                        done_next       = 1'b1;
                        res_next.status = (job_cmd.operation == OP_GET) ? ST_MISS : ST_FULL;
                        state_next      = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_F_RD;
                    end
                end
            end
            B_E_RD:
            begin
                state_next = B_E_HOME;
            end
            B_E_HOME:
            begin
                s_next     = entry_q.home;
                n_next     = '0;
                state_next = B_R_RD;
            end
            B_R_RD:
            begin
                state_next = B_R_CHK;
            end
            B_R_CHK:
            begin
                if (!slot_q.used)
                begin
                    state_next = B_P_WR;
                end
                else if (slot_q.idx == vp_reg)
                begin
                    slot_we    = 1'b1;
                    s_next     = inc_slot(s_reg);
                    m_next     = '0;
                    state_next = B_H_RD;
                end
                else
                begin
                    s_next = inc_slot(s_reg);
                    n_next = n_reg + 1'b1;
                    state_next = (n_reg + 1'b1 == (SW+1)'(SLOT_COUNT)) ? B_P_WR : B_R_RD;
                end
            end
            B_H_RD:
            begin
                state_next = B_H_CHK;
            end
            B_H_CHK:
            begin
                if (!slot_q.used || (m_reg == (SW+1)'(SLOT_COUNT)))
                begin
                    state_next = B_P_WR;
                end
                else
                begin
                    // lift the entry out and re-probe it from its home slot
                    slot_we    = 1'b1;
                    moved_next = slot_q.idx;
                    s_next     = inc_slot(s_reg);
                    m_next     = m_reg + 1'b1;
                    state_next = B_H_ENT;
                end
            end
            B_H_ENT:
            begin
                t_next     = entry_q.home;
                state_next = B_I_RD;
            end
            B_I_RD:
            begin
                state_next = B_I_CHK;
            end
            B_I_CHK:
            begin
                slot_waddr = t_reg;
                if (!slot_q.used)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = '{used: 1'b1, idx: moved_reg};
                    state_next = B_H_RD;
                end
                else
                begin
                    t_next     = inc_slot(t_reg);
                    state_next = B_I_RD;
                end
            end
            B_P_WR:
            begin
                entry_we   = 1'b1;
                s_next     = job_home;
                state_next = B_P_RD;
            end
            B_P_RD:
            begin
                state_next = B_P_CHK;
            end
            B_P_CHK:
            begin
                if (!slot_q.used)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = '{used: 1'b1, idx: vp_reg};
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                    if (vp_reg == EW'(ENTRY_COUNT - 1))
                    begin
                        vp_next   = '0;
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        vp_next = vp_reg + 1'b1;
                    end
                end
                else
                begin
                    s_next     = inc_slot(s_reg);
                    state_next = B_P_RD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        entry_q <= entry_mem[entry_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            s_reg     <= '0;
            vp_reg    <= '0;
            wrap_reg  <= 1'b0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            vp_reg    <= vp_next;
            wrap_reg  <= wrap_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        n_reg     <= n_next;
        m_reg     <= m_next;
        moved_reg <= moved_next;
        job_reg   <= job_next;
    end
endmodule
`default_nettype wire

>>> sim/tb_source_address_info_cache.sv
// Self-checking testbench for the source address info cache.
`timescale 1ns / 1ps
module tb_source_address_info_cache;
    import sac_pkg::*;

    localparam int ENTRIES = ENTRY_COUNT_DEF;
    localparam int SLOTS   = SLOT_COUNT_DEF;
    localparam int POOL    = 700;
    localparam int STALL_LIMIT = 4000000;
    localparam int CMD_W   = $bits(cmd_t);

    // Cache shadow plus the queue of results still owed by the block.
    class addr_cache_scoreboard;
        bit          ent_valid [ENTRIES];
        bit          ent_v6    [ENTRIES];
        logic [63:0] ent_hi    [ENTRIES];
        logic [63:0] ent_lo    [ENTRIES];
        logic [31:0] ent_hash  [ENTRIES];
        logic [7:0]  ent_hop   [ENTRIES];
        logic [63:0] ent_hw    [ENTRIES];
        bit          slot_used [SLOTS];
        int          slot_ent  [SLOTS];
        int          victim;
        result_t     owed[$];
        int          errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 0;
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
            victim = 0;
            errors = 0;
        endfunction

        function logic [31:0] mix32(logic [31:0] x);
            x = x ^ (x >> 16);
            x = x * MIX_MUL_A;
            x = x ^ (x >> 15);
            x = x * MIX_MUL_B;
            x = x ^ (x >> 16);
            return x;
        endfunction

        function logic [31:0] addr_hash(bit v6, logic [63:0] hi, logic [63:0] lo);
            logic [31:0] h;
            logic [127:0] a;
            if (!v6)
                return mix32(lo[31:0] ^ FAM_V4_TAG);
            h = FNV_BASIS;
            a = {hi, lo};
            for (int i = 15; i >= 0; i--)
            begin
                h = h ^ {24'd0, a[i*8 +: 8]};
                h = h * FNV_PRIME;
            end
            return mix32(h ^ FAM_V6_TAG);
        endfunction

        function bit place(int idx);
            int s;
            s = ent_hash[idx] % SLOTS;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!slot_used[s])
                begin
                    slot_used[s] = 1;
                    slot_ent[s] = idx;
                    return 1;
                end
                s = (s + 1) % SLOTS;
            end
            return 0;
        endfunction

        // Free the victim's slot and re-place the rest of its cluster.
        function void evict(int idx);
            int s;
            int moved;
            bit dummy;
            if (!ent_valid[idx]) return;
            s = ent_hash[idx] % SLOTS;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!slot_used[s]) return;
                if (slot_ent[s] == idx)
                begin
                    slot_used[s] = 0;
                    s = (s + 1) % SLOTS;
                    for (int m = 0; m < SLOTS && slot_used[s]; m++)
                    begin
                        moved = slot_ent[s];
                        slot_used[s] = 0;
                        dummy = place(moved);
                        s = (s + 1) % SLOTS;
                    end
                    return;
                end
                s = (s + 1) % SLOTS;
            end
        endfunction

        // 1 found, 0 empty slot reached, -1 table full
        function int probe(bit v6, logic [63:0] hi, logic [63:0] lo,
                           logic [31:0] h, output int where);
            int s;
            int e;
            s = h % SLOTS;
            where = 0;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!slot_used[s])
                begin
                    where = s;
                    return 0;
                end
                e = slot_ent[s];
                if (ent_valid[e] && ent_hash[e] == h && ent_v6[e] == v6 &&
                    ent_hi[e] == hi && ent_lo[e] == lo)
                begin
                    where = s;
                    return 1;
                end
                s = (s + 1) % SLOTS;
            end
            return -1;
        endfunction

        function void note_cmd(cmd_t c);
            logic [63:0] hi;
            logic [63:0] lo;
            logic [31:0] h;
            int r;
            int slot;
            int idx;
            result_t res;
            hi = c.is_ipv6 ? c.addr_high : 64'd0;
            lo = c.is_ipv6 ? c.addr_low : {32'd0, c.addr_low[31:0]};
            h = addr_hash(c.is_ipv6, hi, lo);
            r = probe(c.is_ipv6, hi, lo, h, slot);
            res = '0;
            if (c.operation == OP_GET)
            begin
                if (r == 1)
                begin
                    res.hop_limit_out = ent_hop[slot_ent[slot]];
                    res.hw_address_out = ent_hw[slot_ent[slot]];
                end
                else
                    res.status = ST_MISS;
            end
            else if (r < 0)
                res.status = ST_FULL;
            else
            begin
                if (r == 1)
                    idx = slot_ent[slot];
                else
                begin
                    if (victim >= ENTRIES) victim = 0;
                    idx = victim;
                    evict(idx);
                end
                ent_v6[idx] = c.is_ipv6;
                ent_hi[idx] = hi;
                ent_lo[idx] = lo;
                ent_hash[idx] = h;
                ent_hop[idx] = c.hop_limit;
                ent_hw[idx] = c.hw_address;
                ent_valid[idx] = 1;
                if (r == 0)
                begin
                    if (!place(idx))
                    begin
                        ent_valid[idx] = 0;
                        res.status = ST_FULL;
                    end
                    else
                        victim = (victim + 1) % ENTRIES;
                end
            end
            owed.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            if (got.status !== exp_r.status)
            begin
                $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
                errors++;
            end
            if (got.hop_limit_out !== exp_r.hop_limit_out)
            begin
                $display("%0t: hop limit exp %h got %h", $realtime,
                         exp_r.hop_limit_out, got.hop_limit_out);
                errors++;
            end
            if (got.hw_address_out !== exp_r.hw_address_out)
            begin
                $display("%0t: hw address exp %h got %h", $realtime,
                         exp_r.hw_address_out, got.hw_address_out);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    addr_cache_scoreboard sb;
    int          idle_pct;
    int          stall_cycles;
    bit          key_v6 [POOL];
    logic [63:0] key_hi [POOL];
    logic [63:0] key_lo [POOL];

    source_address_info_cache dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results and accepted beats are both taken from pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(result);
            end
            if (start && !busy)
            begin
                sb.note_cmd(cmd);
            end
            if (done || (start && !busy))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic issue(cmd_t c);
        int gap;
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            cmd <= CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue_fields(logic op, logic v6, logic [63:0] hi, logic [63:0] lo,
                                logic [7:0] hop, logic [63:0] hw);
        cmd_t c;
        c.operation = op;
        c.is_ipv6 = v6;
        c.addr_high = hi;
        c.addr_low = lo;
        c.hop_limit = hop;
        c.hw_address = hw;
        issue(c);
    endtask

    task automatic random_phase(int count);
        int k;
        logic [63:0] hi;
        logic [63:0] lo;
        bit v6;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
            begin
                k = $urandom_range(POOL - 1);
                v6 = key_v6[k];
                hi = key_hi[k];
                lo = key_lo[k];
                // ignored IPv4 bits get fresh noise each time
                if (!v6)
                begin
                    hi = {$urandom, $urandom};
                    lo[63:32] = $urandom;
                end
            end
            else
            begin
                v6 = 1'($urandom_range(1));
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            issue_fields(1'($urandom_range(1)), v6, hi, lo, 8'($urandom),
                         {$urandom, $urandom});
        end
    endtask

    initial
    begin
        sb = new();
        stall_cycles = 0;
        idle_pct = 0;
        rst_n = 0;
        start = 0;
        cmd = '0;
        for (int i = 0; i < POOL; i++)
        begin
            key_v6[i] = 1'($urandom_range(1));
            key_hi[i] = {$urandom, $urandom};
            key_lo[i] = {$urandom, $urandom};
        end
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, miss, hit, update, IPv4 upper bits ignored
        issue_fields(OP_GET, 1'b0, '0, '0, '0, '0);
        issue_fields(OP_PUT, 1'b0, '1, '1, 8'hff, '1);
        issue_fields(OP_GET, 1'b0, '0, 64'h0000_0000_ffff_ffff, '0, '0);
        issue_fields(OP_PUT, 1'b0, '0, '0, 8'h00, '0);
        issue_fields(OP_GET, 1'b0, '1, 64'hffff_ffff_0000_0000, '1, '1);
        issue_fields(OP_PUT, 1'b1, '1, '1, 8'h80, 64'h0123_4567_89ab_cdef);
        issue_fields(OP_GET, 1'b1, '1, '1, '0, '0);
        issue_fields(OP_PUT, 1'b1, '0, '0, 8'h01, 64'hfedc_ba98_7654_3210);
        issue_fields(OP_GET, 1'b1, '0, '0, '0, '0);
        issue_fields(OP_GET, 1'b1, '0, 64'd1, '0, '0);
        issue_fields(OP_PUT, 1'b1, '0, '0, 8'h7f, '1);
        issue_fields(OP_GET, 1'b1, '0, '0, '0, '0);
        issue_fields(OP_PUT, 1'b0, 64'h5555_aaaa_5555_aaaa, 64'h1234_5678_0a00_0001,
                     8'h40, 64'haaaa_5555_aaaa_5555);
        issue_fields(OP_GET, 1'b0, '0, 64'h0000_0000_0a00_0001, '0, '0);
        issue_fields(OP_GET, 1'b1, '0, 64'h0000_0000_0a00_0001, '0, '0);
        issue_fields(OP_GET, 1'b0, '1, '1, '0, '0);

        idle_pct = 19;
        random_phase(650);
        idle_pct = 59;
        random_phase(650);
        idle_pct = 0;
        random_phase(650);
        start <= 1'b0;

        while (sb.owed.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> sim.f
rtl/sac_pkg.sv
rtl/sac_fifo.sv
rtl/sac_front.sv
rtl/sac_back.sv
rtl/source_address_info_cache.sv
sim/tb_source_address_info_cache.sv
